>>> hw/rtl/smcs_pkg.sv
// shared constants, types and arithmetic helpers for the mean and covariance step
package smcs_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int COEF_WIDTH  = 16;
    localparam int SLOT_W      = 16;
    localparam int CFG_W       = 64;
    localparam int LAM_W       = 32;
    localparam int IDX_W       = 3;
    localparam int OUT_W       = 32;
    localparam int CORE_STAGES = 5;

    localparam int W_S1  = 24;
    localparam int W_V2  = 32;
    localparam int W_P2  = 44;
    localparam int W_T3  = 36;
    localparam int W_Q3  = 56;
    localparam int W_T4  = 48;
    localparam int W_SUM = 56;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;

    typedef logic signed [SLOT_W-1:0] t_coef;

    typedef enum logic [IDX_W-1:0] {
        REG_A1, REG_A2, REG_B0, REG_B1, REG_B2, REG_BB, REG_MW, REG_LAM
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] a1;
        logic [CFG_W-1:0] a2;
        logic [CFG_W-1:0] b0;
        logic [CFG_W-1:0] b1;
        logic [CFG_W-1:0] b2;
        logic [CFG_W-1:0] bb;
        logic [CFG_W-1:0] mw;
        logic [LAM_W-1:0] lam;
    } t_cfg;

    // coefficient slot, low COEF_WIDTH bits sign extended
    function automatic t_coef cf(input logic [CFG_W-1:0] r, input int k);
        logic [SLOT_W-1:0] s;
        t_coef t;
        s = r[SLOT_W*k +: SLOT_W];
        t = signed'(s << (SLOT_W - COEF_WIDTH));
        return t >>> (SLOT_W - COEF_WIDTH);
    endfunction

    function automatic logic signed [63:0] mx(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
        return a * b;
    endfunction

    // round half upward
    function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
        return (x + HALF) >>> FRAC_BITS;
    endfunction

endpackage

>>> hw/rtl/smcs_core.sv
// five stage datapath: products, rounding and partial sums of mean and covariance
module smcs_core
    import smcs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_cfg                    i_cfg,
    input  t_coef                   i_u [2],
    input  t_coef                   i_d [2],
    input  logic signed [31:0]      i_p [2][2],
    output logic                    o_vld,
    output logic signed [W_SUM-1:0] o_rho [2],
    output logic signed [W_SUM-1:0] o_g [2][2],
    output logic signed [W_SUM-1:0] o_v [2][2],
    output logic signed [W_SUM-1:0] o_q [2][2]
);

    logic [CORE_STAGES-1:0] r_vld;

    t_coef a1 [2][2], a2 [2][2], b0 [2][2], b1 [2][2], b2 [2][2], bb [2][2];
    t_coef w0, w1, g0, g1;
    t_coef lam [2];

    // stage 1
    logic signed [W_S1-1:0] r1_wp [2][2], n1_wp [2][2];
    logic signed [W_S1-1:0] r1_dm [2][2], n1_dm [2][2];
    logic signed [W_S1-1:0] r1_ga1 [2][2], n1_ga1 [2][2];
    logic signed [W_S1-1:0] r1_ga2 [2][2], n1_ga2 [2][2];
    logic signed [W_S1-1:0] r1_gb1 [2][2], n1_gb1 [2][2];
    logic signed [W_S1-1:0] r1_gb2 [2][2], n1_gb2 [2][2];
    logic signed [W_S1-1:0] r1_bu [2], n1_bu [2];
    t_coef                  r1_u [2], r1_d [2];
    logic signed [31:0]     r1_p [2][2];

    // stage 2
    logic signed [W_V2-1:0] r2_wd [2], n2_wd [2];
    logic signed [W_V2-1:0] r2_dl [2], n2_dl [2];
    logic signed [W_V2-1:0] r2_g1d [2], n2_g1d [2];
    logic signed [W_V2-1:0] r2_g2d [2], n2_g2d [2];
    logic signed [W_V2-1:0] r2_b1l [2], n2_b1l [2];
    logic signed [W_V2-1:0] r2_b2l [2], n2_b2l [2];
    logic signed [W_V2-1:0] r2_buu [2][2], n2_buu [2][2];
    logic signed [W_P2-1:0] r2_wpp [2][2], n2_wpp [2][2];
    logic signed [W_P2-1:0] r2_g1p [2][2], n2_g1p [2][2];
    logic signed [W_P2-1:0] r2_g2p [2][2], n2_g2p [2][2];
    logic signed [W_S1-1:0] r2_wp [2][2], r2_dm [2][2], r2_bu [2];
    t_coef                  r2_u [2];

    // stage 3
    logic signed [W_SUM-1:0] r3_rho [2], n3_rho [2];
    logic signed [W_T3-1:0]  r3_t [9][2][2], n3_t [9][2][2];
    logic signed [W_Q3-1:0]  r3_q [3][2][2], n3_q [3][2][2];
    logic signed [W_S1-1:0]  r3_dm [2][2];

    // stage 4
    logic signed [W_T4-1:0]  r4_x [9][2][2], n4_x [9][2][2];
    logic signed [W_Q3-1:0]  r4_q [3][2][2];
    logic signed [W_SUM-1:0] r4_rho [2];

    // stage 5
    logic signed [W_SUM-1:0] r5_g [2][2], n5_g [2][2];
    logic signed [W_SUM-1:0] r5_v [2][2], n5_v [2][2];
    logic signed [W_SUM-1:0] r5_q [2][2], n5_q [2][2];
    logic signed [W_SUM-1:0] r5_rho [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                a1[i][j] = cf(i_cfg.a1, 2*i + j);
                a2[i][j] = cf(i_cfg.a2, 2*i + j);
                b0[i][j] = cf(i_cfg.b0, 2*i + j);
                b1[i][j] = cf(i_cfg.b1, 2*i + j);
                b2[i][j] = cf(i_cfg.b2, 2*i + j);
                bb[i][j] = cf(i_cfg.bb, 2*i + j);
            end
            lam[i] = cf({{(CFG_W-LAM_W){1'b0}}, i_cfg.lam}, i);
        end
        w0 = cf(i_cfg.mw, 0);
        w1 = cf(i_cfg.mw, 1);
        g0 = cf(i_cfg.mw, 2);
        g1 = cf(i_cfg.mw, 3);
    end

    // stage 1: scaled mode matrices and B u
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                n1_wp[i][j] = W_S1'(((i == j) ? ONE : 64'sd0)
                              + rnd(mx(w0, a1[i][j])) + rnd(mx(w1, a2[i][j])));
                n1_dm[i][j] = W_S1'(64'(b0[i][j])
                              + rnd(mx(w0, b1[i][j])) + rnd(mx(w1, b2[i][j])));
                n1_ga1[i][j] = W_S1'(rnd(mx(g0, a1[i][j])));
                n1_ga2[i][j] = W_S1'(rnd(mx(g1, a2[i][j])));
                n1_gb1[i][j] = W_S1'(rnd(mx(g0, b1[i][j])));
                n1_gb2[i][j] = W_S1'(rnd(mx(g1, b2[i][j])));
            end
            n1_bu[i] = W_S1'(rnd(mx(bb[i][0], i_u[0]) + mx(bb[i][1], i_u[1])));
        end
    end

    // stage 2: matrix by vector, matrix by covariance and the outer product of B u and u
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n2_wd[i]  = W_V2'(rnd(mx(r1_wp[i][0], r1_d[0]) + mx(r1_wp[i][1], r1_d[1])));
            n2_dl[i]  = W_V2'(rnd(mx(r1_dm[i][0], lam[0]) + mx(r1_dm[i][1], lam[1])));
            n2_g1d[i] = W_V2'(rnd(mx(r1_ga1[i][0], r1_d[0]) + mx(r1_ga1[i][1], r1_d[1])));
            n2_g2d[i] = W_V2'(rnd(mx(r1_ga2[i][0], r1_d[0]) + mx(r1_ga2[i][1], r1_d[1])));
            n2_b1l[i] = W_V2'(rnd(mx(r1_gb1[i][0], lam[0]) + mx(r1_gb1[i][1], lam[1])));
            n2_b2l[i] = W_V2'(rnd(mx(r1_gb2[i][0], lam[0]) + mx(r1_gb2[i][1], lam[1])));
            for (int j = 0; j < 2; j++) begin
                n2_buu[i][j] = W_V2'(rnd(mx(r1_bu[i], r1_u[j])));
                n2_wpp[i][j] = W_P2'(rnd(mx(r1_wp[i][0], r1_p[0][j])
                                         + mx(r1_wp[i][1], r1_p[1][j])));
                n2_g1p[i][j] = W_P2'(rnd(mx(r1_ga1[i][0], r1_p[0][j])
                                         + mx(r1_ga1[i][1], r1_p[1][j])));
                n2_g2p[i][j] = W_P2'(rnd(mx(r1_ga2[i][0], r1_p[0][j])
                                         + mx(r1_ga2[i][1], r1_p[1][j])));
            end
        end
    end

    // stage 3: outer products, mean sum and right factors of the covariance
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n3_rho[i] = W_SUM'(64'(r2_wd[i]) + 64'(r2_dl[i]) + 64'(r2_bu[i]));
            for (int j = 0; j < 2; j++) begin
                n3_t[0][i][j] = W_T3'(rnd(mx(r2_wd[i], r2_u[j])));
                n3_t[1][i][j] = W_T3'(rnd(mx(r2_dl[i], r2_u[j])));
                n3_t[2][i][j] = W_T3'(rnd(mx(r2_wd[i], lam[j])));
                n3_t[3][i][j] = W_T3'(rnd(mx(r2_g1d[i], lam[j])));
                n3_t[4][i][j] = W_T3'(rnd(mx(r2_g2d[i], lam[j])));
                n3_t[5][i][j] = W_T3'(rnd(mx(r2_buu[i][0], bb[j][0])
                                          + mx(r2_buu[i][1], bb[j][1])));
                n3_t[6][i][j] = W_T3'(rnd(mx(r2_dl[i], lam[j])));
                n3_t[7][i][j] = W_T3'(rnd(mx(r2_b1l[i], lam[j])));
                n3_t[8][i][j] = W_T3'(rnd(mx(r2_b2l[i], lam[j])));
                n3_q[0][i][j] = W_Q3'(rnd(mx(r2_wpp[i][0], r2_wp[j][0])
                                          + mx(r2_wpp[i][1], r2_wp[j][1])));
                n3_q[1][i][j] = W_Q3'(rnd(mx(r2_g1p[i][0], a1[j][0])
                                          + mx(r2_g1p[i][1], a1[j][1])));
                n3_q[2][i][j] = W_Q3'(rnd(mx(r2_g2p[i][0], a2[j][0])
                                          + mx(r2_g2p[i][1], a2[j][1])));
            end
        end
    end

    // stage 4: right factors of the cross and noise terms
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                n4_x[0][i][j] = W_T4'(rnd(mx(r3_t[0][i][0], bb[j][0])
                                          + mx(r3_t[0][i][1], bb[j][1])));
                n4_x[1][i][j] = W_T4'(rnd(mx(r3_t[1][i][0], bb[j][0])
                                          + mx(r3_t[1][i][1], bb[j][1])));
                n4_x[2][i][j] = W_T4'(rnd(mx(r3_t[2][i][0], r3_dm[j][0])
                                          + mx(r3_t[2][i][1], r3_dm[j][1])));
                n4_x[3][i][j] = W_T4'(rnd(mx(r3_t[3][i][0], b1[j][0])
                                          + mx(r3_t[3][i][1], b1[j][1])));
                n4_x[4][i][j] = W_T4'(rnd(mx(r3_t[4][i][0], b2[j][0])
                                          + mx(r3_t[4][i][1], b2[j][1])));
                n4_x[5][i][j] = W_T4'(r3_t[5][i][j]);
                n4_x[6][i][j] = W_T4'(rnd(mx(r3_t[6][i][0], r3_dm[j][0])
                                          + mx(r3_t[6][i][1], r3_dm[j][1])));
                n4_x[7][i][j] = W_T4'(rnd(mx(r3_t[7][i][0], b1[j][0])
                                          + mx(r3_t[7][i][1], b1[j][1])));
                n4_x[8][i][j] = W_T4'(rnd(mx(r3_t[8][i][0], b2[j][0])
                                          + mx(r3_t[8][i][1], b2[j][1])));
            end
        end
    end

    // stage 5: partial sums
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                n5_g[i][j] = W_SUM'(64'(r4_x[0][i][j]) + 64'(r4_x[1][i][j])
                             + 64'(r4_x[2][i][j]) + 64'(r4_x[3][i][j])
                             + 64'(r4_x[4][i][j]));
                n5_v[i][j] = W_SUM'(64'(r4_x[5][i][j]) + 64'(r4_x[6][i][j])
                             + 64'(r4_x[7][i][j]) + 64'(r4_x[8][i][j]));
                n5_q[i][j] = W_SUM'(64'(r4_q[0][i][j]) + 64'(r4_q[1][i][j])
                             + 64'(r4_q[2][i][j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CORE_STAGES-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_wp  <= n1_wp;
        r1_dm  <= n1_dm;
        r1_ga1 <= n1_ga1;
        r1_ga2 <= n1_ga2;
        r1_gb1 <= n1_gb1;
        r1_gb2 <= n1_gb2;
        r1_bu  <= n1_bu;
        r1_u   <= i_u;
        r1_d   <= i_d;
        r1_p   <= i_p;

        r2_wd  <= n2_wd;
        r2_dl  <= n2_dl;
        r2_g1d <= n2_g1d;
        r2_g2d <= n2_g2d;
        r2_b1l <= n2_b1l;
        r2_b2l <= n2_b2l;
        r2_buu <= n2_buu;
        r2_wpp <= n2_wpp;
        r2_g1p <= n2_g1p;
        r2_g2p <= n2_g2p;
        r2_wp  <= r1_wp;
        r2_dm  <= r1_dm;
        r2_bu  <= r1_bu;
        r2_u   <= r1_u;

        r3_rho <= n3_rho;
        r3_t   <= n3_t;
        r3_q   <= n3_q;
        r3_dm  <= r2_dm;

        r4_x   <= n4_x;
        r4_q   <= r3_q;
        r4_rho <= r3_rho;

        r5_g   <= n5_g;
        r5_v   <= n5_v;
        r5_q   <= n5_q;
        r5_rho <= r4_rho;
    end

    assign o_vld = r_vld[CORE_STAGES-1];
    assign o_rho = r5_rho;
    assign o_g   = r5_g;
    assign o_v   = r5_v;
    assign o_q   = r5_q;

endmodule

>>> hw/rtl/stochastic_mean_covariance_step_top.sv
// top level of the mean and covariance step with configuration registers
// a request taken at an edge passes the core datapath stages and then the output register before its result strobe
// throughput: one request per cycle, busy never rises; six register stages
// the receiver cannot stall, results are shown for exactly one cycle
// reset: synchronous active low, clears configuration to zero and all valid bits
module stochastic_mean_covariance_step_top
    import smcs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic signed [15:0]      i_control_u0,
    input  logic signed [15:0]      i_control_u1,
    input  logic signed [15:0]      i_density_0,
    input  logic signed [15:0]      i_density_1,
    input  logic signed [31:0]      i_prev_cov_00,
    input  logic signed [31:0]      i_prev_cov_01,
    input  logic signed [31:0]      i_prev_cov_10,
    input  logic signed [31:0]      i_prev_cov_11,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_mean_next_0,
    output logic signed [OUT_W-1:0] o_mean_next_1,
    output logic signed [OUT_W-1:0] o_cov_next_00,
    output logic signed [OUT_W-1:0] o_cov_next_01,
    output logic signed [OUT_W-1:0] o_cov_next_10,
    output logic signed [OUT_W-1:0] o_cov_next_11,
    output logic                    o_saturated
);

    localparam logic signed [W_SUM+1:0] SAT_MAX = (W_SUM+2)'(64'sh7FFFFFFF);
    localparam logic signed [W_SUM+1:0] SAT_MIN = (W_SUM+2)'(-64'sh80000000);

    t_cfg r_cfg;
    logic r_valid;
    logic signed [OUT_W-1:0] r_out [6], n_out [6];
    logic r_sat, n_sat;

    t_coef u [2], d [2];
    logic signed [31:0] p [2][2];
    logic core_vld;
    logic signed [W_SUM-1:0] c_rho [2], c_g [2][2], c_v [2][2], c_q [2][2];
    logic signed [W_SUM+1:0] full [6];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_A1:  r_cfg.a1  <= i_cfg_data;
                REG_A2:  r_cfg.a2  <= i_cfg_data;
                REG_B0:  r_cfg.b0  <= i_cfg_data;
                REG_B1:  r_cfg.b1  <= i_cfg_data;
                REG_B2:  r_cfg.b2  <= i_cfg_data;
                REG_BB:  r_cfg.bb  <= i_cfg_data;
                REG_MW:  r_cfg.mw  <= i_cfg_data;
                REG_LAM: r_cfg.lam <= i_cfg_data[LAM_W-1:0];
                default: r_cfg     <= r_cfg;
            endcase
        end
    end

    assign u[0]    = i_control_u0;
    assign u[1]    = i_control_u1;
    assign d[0]    = i_density_0;
    assign d[1]    = i_density_1;
    assign p[0][0] = i_prev_cov_00;
    assign p[0][1] = i_prev_cov_01;
    assign p[1][0] = i_prev_cov_10;
    assign p[1][1] = i_prev_cov_11;

    smcs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start & ~busy),
        .i_cfg   (r_cfg),
        .i_u     (u),
        .i_d     (d),
        .i_p     (p),
        .o_vld   (core_vld),
        .o_rho   (c_rho),
        .o_g     (c_g),
        .o_v     (c_v),
        .o_q     (c_q)
    );

    // final sums and clipping to 32 bits
    always_comb begin
        full[0] = (W_SUM+2)'(c_rho[0]);
        full[1] = (W_SUM+2)'(c_rho[1]);
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                full[2 + 2*i + j] = (W_SUM+2)'(c_q[i][j]) + (W_SUM+2)'(c_g[i][j])
                                  + (W_SUM+2)'(c_g[j][i]) + (W_SUM+2)'(c_v[i][j]);
            end
        end
        n_sat = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (full[k] > SAT_MAX) begin
                n_out[k] = OUT_W'(SAT_MAX);
                n_sat    = 1'b1;
            end else if (full[k] < SAT_MIN) begin
                n_out[k] = OUT_W'(SAT_MIN);
                n_sat    = 1'b1;
            end else begin
                n_out[k] = OUT_W'(full[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= core_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sat <= n_sat;
    end

    assign o_valid       = r_valid;
    assign o_mean_next_0 = r_out[0];
    assign o_mean_next_1 = r_out[1];
    assign o_cov_next_00 = r_out[2];
    assign o_cov_next_01 = r_out[3];
    assign o_cov_next_10 = r_out[4];
    assign o_cov_next_11 = r_out[5];
    assign o_saturated   = r_sat;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_valid)
        else $error("request did not produce a result after six cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(core_vld, 1))
        else $error("result strobe without a request leaving the datapath");

    a_core_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 core_vld)
        else $error("datapath valid lost in flight");
`endif

endmodule
